[rtl/max_flow_edmonds_karp_unit_assert.svh]
// Assertion macros for the max flow unit checker.
// Used by the port-level checker only.
`ifndef MAX_FLOW_EDMONDS_KARP_UNIT_ASSERT_SVH
`define MAX_FLOW_EDMONDS_KARP_UNIT_ASSERT_SVH
// assert that a implies b on the next edge
`define MFEK_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
// assert that a implies b on the same edge
`define MFEK_ASSERT_NOW(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`endif

[rtl/mfek_pkg.sv]
// Package for the max flow unit: sizes, command codes, state encoding.
// No dependencies.
package mfek_pkg;
    localparam int MAX_NODES     = 64;
    localparam int CAPACITY_BITS = 16;
    localparam int NODE_W        = $clog2(MAX_NODES);
    localparam int ADDR_W        = 2 * NODE_W;
    localparam int ENTRY_W       = CAPACITY_BITS + 1;
    localparam int FLOW_W        = 22;
    localparam int CNT_W         = NODE_W + 1;

    typedef enum logic [1:0] {
        CMD_WRITE = 2'd0,
        CMD_RUN   = 2'd1,
        CMD_READ  = 2'd2,
        CMD_CLEAR = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RD_WAIT,
        ST_CLEAR,
        ST_BFS_INIT,
        ST_VIS_CLR,
        ST_POP,
        ST_POP_WAIT,
        ST_SCAN,
        ST_SCAN_WAIT,
        ST_NECK_RD,
        ST_NECK_WAIT,
        ST_UPD_FWD_RD,
        ST_UPD_FWD_WAIT,
        ST_UPD_REV_RD,
        ST_UPD_REV_WAIT,
        ST_DONE,
        ST_OUT
    } state_t;
endpackage

[rtl/mfek_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module mfek_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

[rtl/max_flow_edmonds_karp_unit.sv]
// Max flow unit (Edmonds-Karp) over a 64x64 residual matrix held in a RAM.
// Depends on mfek_pkg and mfek_ram.
//
// Input channel: valid/stall with cmd, from_node, to_node, capacity.
// Output channel: valid/stall with value; one result transaction per input.
// Config: cfg_we/cfg_data write inner_node_count; write only while idle.
// Write and clear return value 0; read returns the stored entry.
// Clear writes one matrix entry per cycle through the single RAM write port;
// read waits for the registered RAM read before raising its result.
// Run: each search clears all 64 visited flags, then pops each queued node
// and scans its row column by column until the sink is popped or the queue
// empties; each augmenting path is then walked twice, for its bottleneck and
// then to update its forward and reverse entries. The matrix RAM port bounds all of this.
// Reset clears the matrix by a sweep during which no transaction
// is taken (in_stall high) and no result is raised; config writes are still
// accepted.
// A finished result waits in the output register while out_stall is high; the
// next transaction is taken only once the output has been taken.
module max_flow_edmonds_karp_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [5:0]  from_node,
    input  logic [5:0]  to_node,
    input  logic [15:0] capacity,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [21:0] value
);
    localparam int NW = mfek_pkg::NODE_W;
    localparam int AW = mfek_pkg::ADDR_W;
    localparam int EW = mfek_pkg::ENTRY_W;
    localparam int FW = mfek_pkg::FLOW_W;
    localparam int CW = mfek_pkg::CNT_W;
    localparam logic [EW-1:0] ENTRY_MAX = '1;
    localparam logic [FW-1:0] FLOW_MAX  = '1;

    mfek_pkg::state_t state_reg, state_next;
    logic [5:0]    inner_reg;
    logic [CW-1:0] n_reg, n_next;
    logic [AW:0]   clr_reg, clr_next;
    logic          boot_reg, boot_next;
    logic          out_valid_reg, out_valid_next;
    logic [FW-1:0] value_reg, value_next;
    logic [FW-1:0] flow_reg, flow_next;
    logic [NW-1:0] from_reg, from_next, to_reg, to_next;
    logic [NW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [CW-1:0] count_reg, count_next;
    logic [NW-1:0] u_reg, u_next, v_reg, v_next, w_reg, w_next;
    logic [CW-1:0] col_reg, col_next;
    logic [EW-1:0] neck_reg, neck_next;

    logic          m_we;
    logic [AW-1:0] m_waddr, m_raddr;
    logic [EW-1:0] m_wdata, m_rdata;
    logic          q_we;
    logic [NW-1:0] q_waddr, q_raddr, q_wdata, q_rdata;
    logic          p_we;
    logic [NW-1:0] p_waddr, p_raddr, p_wdata, p_rdata;
    logic          vis_we;
    logic [NW-1:0] vis_waddr, vis_raddr;
    logic [0:0]    vis_wdata, vis_rdata;

    logic [NW-1:0] sink;
    logic [CW-1:0] n_calc;
    logic [EW-1:0] rev_sum;
    logic [FW:0]   flow_sum;

    mfek_ram #(.WIDTH(EW), .DEPTH(mfek_pkg::MAX_NODES * mfek_pkg::MAX_NODES)) u_matrix (
        .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
        .raddr(m_raddr), .rdata(m_rdata));
    mfek_ram #(.WIDTH(NW), .DEPTH(mfek_pkg::MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata));
    mfek_ram #(.WIDTH(NW), .DEPTH(mfek_pkg::MAX_NODES)) u_parent (
        .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
        .raddr(p_raddr), .rdata(p_rdata));
    mfek_ram #(.WIDTH(1), .DEPTH(mfek_pkg::MAX_NODES)) u_visited (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_reg <= 6'd62;
        end
        else if (cfg_we)
        begin
            inner_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= mfek_pkg::ST_CLEAR;
            clr_reg       <= '0;
            boot_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
            flow_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            boot_reg      <= boot_next;
            out_valid_reg <= out_valid_next;
            flow_reg      <= flow_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg     <= n_next;
        value_reg <= value_next;
        from_reg  <= from_next;
        to_reg    <= to_next;
        head_reg  <= head_next;
        tail_reg  <= tail_next;
        count_reg <= count_next;
        u_reg     <= u_next;
        v_reg     <= v_next;
        w_reg     <= w_next;
        col_reg   <= col_next;
        neck_reg  <= neck_next;
    end

    // active node count saturates at MAX_NODES
    always_comb
    begin
        if ({1'b0, inner_reg} + 7'd2 > 7'(mfek_pkg::MAX_NODES))
            n_calc = CW'(mfek_pkg::MAX_NODES);
        else
            n_calc = CW'({1'b0, inner_reg} + 7'd2);
    end
    assign sink = NW'(n_reg - CW'(1));
    assign rev_sum = (ENTRY_MAX - m_rdata < neck_reg) ? ENTRY_MAX : m_rdata + neck_reg;
    assign flow_sum = {1'b0, flow_reg} + (FW+1)'(neck_reg);

    assign in_stall  = !(state_reg == mfek_pkg::ST_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign value     = value_reg;

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        boot_next      = boot_reg;
        out_valid_next = out_valid_reg;
        value_next     = value_reg;
        flow_next      = flow_reg;
        n_next         = n_reg;
        from_next      = from_reg;
        to_next        = to_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        u_next         = u_reg;
        v_next         = v_reg;
        w_next         = w_reg;
        col_next       = col_reg;
        neck_next      = neck_reg;
        m_we    = 1'b0;
        m_waddr = '0;
        m_wdata = '0;
        m_raddr = {from_reg, to_reg};
        q_we    = 1'b0;
        q_waddr = '0;
        q_wdata = '0;
        q_raddr = head_reg;
        p_we    = 1'b0;
        p_waddr = '0;
        p_wdata = '0;
        p_raddr = v_reg;
        vis_we    = 1'b0;
        vis_waddr = '0;
        vis_wdata = '0;
        vis_raddr = NW'(col_reg);

        if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;

        case (state_reg)
            mfek_pkg::ST_IDLE:
            begin
                if (in_valid && !in_stall)
                begin
                    from_next = from_node;
                    to_next   = to_node;
                    case (mfek_pkg::cmd_t'(cmd))
                        mfek_pkg::CMD_WRITE:
                        begin
                            m_we           = 1'b1;
                            m_waddr        = {from_node, to_node};
                            m_wdata        = {1'b0, capacity};
                            value_next     = '0;
                            out_valid_next = 1'b1;
                        end
                        mfek_pkg::CMD_RUN:
                        begin
                            n_next     = n_calc;
                            flow_next  = '0;
                            state_next = mfek_pkg::ST_BFS_INIT;
                        end
                        mfek_pkg::CMD_READ:
                        begin
                            m_raddr    = {from_node, to_node};
                            state_next = mfek_pkg::ST_RD_WAIT;
                        end
                        default:
                        begin
                            clr_next   = '0;
                            state_next = mfek_pkg::ST_CLEAR;
                        end
                    endcase
                end
            end
            mfek_pkg::ST_RD_WAIT:
            begin
                value_next     = FW'(m_rdata);
                out_valid_next = 1'b1;
                state_next     = mfek_pkg::ST_IDLE;
            end
            mfek_pkg::ST_CLEAR:
            begin
                if (clr_reg[AW])
                begin
                    // no result for the sweep after reset
                    value_next     = '0;
                    out_valid_next = !boot_reg;
                    boot_next      = 1'b0;
                    state_next     = mfek_pkg::ST_DONE;
                end
                else
                begin
                    m_we     = 1'b1;
                    m_waddr  = clr_reg[AW-1:0];
                    clr_next = clr_reg + 1'b1;
                end
            end
            mfek_pkg::ST_DONE:
            begin
                state_next = mfek_pkg::ST_IDLE;
            end
            mfek_pkg::ST_BFS_INIT:
            begin
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = '0;
                head_next  = '0;
                tail_next  = NW'(1);
                count_next = CW'(1);
                col_next   = '0;
                state_next = mfek_pkg::ST_VIS_CLR;
            end
            mfek_pkg::ST_VIS_CLR:
            begin
                // source is marked, every other node cleared
                vis_we    = 1'b1;
                vis_waddr = NW'(col_reg);
                vis_wdata = 1'(col_reg == '0);
                if (col_reg == CW'(mfek_pkg::MAX_NODES - 1))
                    state_next = mfek_pkg::ST_POP;
                else
                    col_next = col_reg + 1'b1;
            end
            mfek_pkg::ST_POP:
            begin
                if (count_reg == '0)
                begin
                    value_next     = flow_reg;
                    out_valid_next = 1'b1;
                    state_next     = mfek_pkg::ST_IDLE;
                end
                else
                begin
                    q_raddr    = head_reg;
                    count_next = count_reg - 1'b1;
                    state_next = mfek_pkg::ST_POP_WAIT;
                end
            end
            mfek_pkg::ST_POP_WAIT:
            begin
                u_next = q_rdata;
                if (q_rdata == sink)
                begin
                    v_next     = sink;
                    neck_next  = ENTRY_MAX;
                    state_next = mfek_pkg::ST_NECK_RD;
                end
                else
                begin
                    col_next   = '0;
                    state_next = mfek_pkg::ST_SCAN;
                end
            end
            mfek_pkg::ST_SCAN:
            begin
                if (col_reg == n_reg)
                begin
                    head_next  = (CW'(head_reg) + 1'b1 == n_reg) ? '0 : head_reg + 1'b1;
                    state_next = mfek_pkg::ST_POP;
                end
                else
                begin
                    m_raddr    = {u_reg, NW'(col_reg)};
                    vis_raddr  = NW'(col_reg);
                    state_next = mfek_pkg::ST_SCAN_WAIT;
                end
            end
            mfek_pkg::ST_SCAN_WAIT:
            begin
                if (m_rdata != '0 && !vis_rdata[0])
                begin
                    q_we    = 1'b1;
                    q_waddr = tail_reg;
                    q_wdata = NW'(col_reg);
                    p_we    = 1'b1;
                    p_waddr = NW'(col_reg);
                    p_wdata = u_reg;
                    tail_next = (CW'(tail_reg) + 1'b1 == n_reg) ? '0 : tail_reg + 1'b1;
                    vis_we    = 1'b1;
                    vis_waddr = NW'(col_reg);
                    vis_wdata = 1'b1;
                    count_next = count_reg + 1'b1;
                end
                col_next   = col_reg + 1'b1;
                state_next = mfek_pkg::ST_SCAN;
            end
            mfek_pkg::ST_NECK_RD:
            begin
                if (v_reg == '0)
                begin
                    v_next     = sink;
                    state_next = mfek_pkg::ST_UPD_FWD_RD;
                end
                else
                begin
                    p_raddr    = v_reg;
                    col_next   = '0;
                    state_next = mfek_pkg::ST_NECK_WAIT;
                end
            end
            mfek_pkg::ST_NECK_WAIT:
            begin
                // first cycle: parent ready, issue the matrix read
                if (col_reg == '0)
                begin
                    w_next   = p_rdata;
                    m_raddr  = {p_rdata, v_reg};
                    col_next = CW'(1);
                end
                else
                begin
                    if (m_rdata < neck_reg)
                        neck_next = m_rdata;
                    v_next     = w_reg;
                    state_next = mfek_pkg::ST_NECK_RD;
                end
            end
            mfek_pkg::ST_UPD_FWD_RD:
            begin
                if (v_reg == '0)
                begin
                    flow_next  = flow_sum[FW] ? FLOW_MAX : flow_sum[FW-1:0];
                    state_next = mfek_pkg::ST_BFS_INIT;
                end
                else
                begin
                    p_raddr    = v_reg;
                    col_next   = '0;
                    state_next = mfek_pkg::ST_UPD_FWD_WAIT;
                end
            end
            mfek_pkg::ST_UPD_FWD_WAIT:
            begin
                if (col_reg == '0)
                begin
                    w_next   = p_rdata;
                    m_raddr  = {p_rdata, v_reg};
                    col_next = CW'(1);
                end
                else
                begin
                    m_we       = 1'b1;
                    m_waddr    = {w_reg, v_reg};
                    m_wdata    = m_rdata - neck_reg;
                    state_next = mfek_pkg::ST_UPD_REV_RD;
                end
            end
            mfek_pkg::ST_UPD_REV_RD:
            begin
                m_raddr    = {v_reg, w_reg};
                state_next = mfek_pkg::ST_UPD_REV_WAIT;
            end
            mfek_pkg::ST_UPD_REV_WAIT:
            begin
                m_we       = 1'b1;
                m_waddr    = {v_reg, w_reg};
                m_wdata    = rev_sum;
                v_next     = w_reg;
                state_next = mfek_pkg::ST_UPD_FWD_RD;
            end
            default:
            begin
                state_next = mfek_pkg::ST_IDLE;
            end
        endcase
    end
endmodule

[rtl/mfek_checker.sv]
// Port-level checker for the max flow unit, bound to the top level.
// Depends on max_flow_edmonds_karp_unit_assert.svh.
`include "max_flow_edmonds_karp_unit_assert.svh"
module mfek_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        out_valid,
    input logic        out_stall,
    input logic [21:0] value
);
    `MFEK_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(value))
    `MFEK_ASSERT_NOW(a_busy_while_out, clk, rst_n, out_valid, in_stall)
    `MFEK_ASSERT_NEXT(a_one_result, clk, rst_n, in_valid && !in_stall, !(out_valid && in_valid && !in_stall))
endmodule

bind max_flow_edmonds_karp_unit mfek_checker u_mfek_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .value(value));

[tb/mfek_flow_checker.sv]
// Checker for the max flow unit: predicts each result from the accepted transactions.
// It watches the config and both channels and reports a failure count and the number of
// results still due. Depends on mfek_pkg.
module mfek_flow_checker
    import mfek_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [5:0]  cfg_data,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [5:0]  from_node,
    input  logic [5:0]  to_node,
    input  logic [15:0] capacity,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [21:0] value,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [ENTRY_W-1:0] ENTRY_FULL = '1;
    localparam logic [FLOW_W-1:0]  FLOW_FULL  = '1;

    logic [ENTRY_W-1:0] residual [MAX_NODES*MAX_NODES];
    logic [NODE_W-1:0]  inner_nodes;
    logic [FLOW_W-1:0]  flow_due [$];
    bit                 seen [MAX_NODES];
    int                 came_from [MAX_NODES];
    int                 frontier [MAX_NODES];

    function automatic bit sink_reachable(int nodes);
        int head;
        int tail;
        int count;
        int u;
        head = 0;
        tail = 1;
        count = 1;
        for (int i = 0; i < MAX_NODES; i++)
            seen[i] = 1'b0;
        frontier[0] = 0;
        seen[0] = 1'b1;
        while (count > 0)
        begin
            u = frontier[head];
            count--;
            if (u == nodes - 1)
                return 1'b1;
            for (int v = 0; v < nodes; v++)
            begin
                if (residual[u*MAX_NODES+v] != 0 && !seen[v])
                begin
                    frontier[tail] = v;
                    came_from[v] = u;
                    tail = (tail + 1) % nodes;
                    seen[v] = 1'b1;
                    count++;
                end
            end
            head = (head + 1) % nodes;
        end
        return 1'b0;
    endfunction

    function automatic logic [FLOW_W-1:0] max_flow();
        int nodes;
        int v;
        int u;
        logic [ENTRY_W-1:0] neck;
        logic [FLOW_W:0]    total;
        logic [ENTRY_W:0]   grown;
        nodes = int'(inner_nodes) + 2;
        if (nodes > MAX_NODES)
            nodes = MAX_NODES;
        total = '0;
        while (sink_reachable(nodes))
        begin
            neck = ENTRY_FULL;
            for (v = nodes - 1; v != 0; v = came_from[v])
                if (residual[came_from[v]*MAX_NODES+v] < neck)
                    neck = residual[came_from[v]*MAX_NODES+v];
            for (v = nodes - 1; v != 0; v = came_from[v])
            begin
                u = came_from[v];
                residual[u*MAX_NODES+v] -= neck;
                grown = residual[v*MAX_NODES+u] + neck;
                residual[v*MAX_NODES+u] = grown > ENTRY_FULL ? ENTRY_FULL : grown[ENTRY_W-1:0];
            end
            total = total + neck;
            if (total > FLOW_FULL)
                total = FLOW_FULL;
        end
        return total[FLOW_W-1:0];
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_NODES*MAX_NODES; i++)
                residual[i] = '0;
            inner_nodes = 6'd62;
            flow_due.delete();
            errors <= 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (flow_due.size() == 0)
                begin
                    $error("value: no result expected, actual %0d", value);
                    errors <= errors + 1;
                end
                else if (value !== flow_due[0])
                begin
                    $error("value: expected %0d, actual %0d", flow_due[0], value);
                    errors <= errors + 1;
                    void'(flow_due.pop_front());
                end
                else
                    void'(flow_due.pop_front());
            end
            if (cfg_we)
                inner_nodes = cfg_data;
            if (in_valid && !in_stall)
            begin
                case (cmd_t'(cmd))
                    CMD_WRITE:
                    begin
                        residual[from_node*MAX_NODES+to_node] = {1'b0, capacity};
                        flow_due.push_back('0);
                    end
                    CMD_RUN:
                        flow_due.push_back(max_flow());
                    CMD_READ:
                        flow_due.push_back(FLOW_W'(residual[from_node*MAX_NODES+to_node]));
                    default:
                    begin
                        for (int i = 0; i < MAX_NODES*MAX_NODES; i++)
                            residual[i] = '0;
                        flow_due.push_back('0);
                    end
                endcase
            end
            pending <= flow_due.size();
        end
    end
endmodule

[tb/tb.sv]
// Testbench top for the max flow unit: reset, config phases, directed and random traffic.
// Depends on mfek_pkg, max_flow_edmonds_karp_unit and mfek_flow_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import mfek_pkg::*;

    localparam int STALL_LIMIT = 20000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [5:0]  cfg_data = '0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd = CMD_WRITE;
    logic [5:0]  from_node = '0;
    logic [5:0]  to_node = '0;
    logic [15:0] capacity = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [21:0] value;
    int          errors;
    int          pending;
    int          send_gap_pct = 0;
    int          recv_gap_pct = 0;
    int          quiet_cycles = 0;
    int          nodes;

    always #5 clk = ~clk;

    max_flow_edmonds_karp_unit DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .from_node(from_node),
        .to_node(to_node), .capacity(capacity), .out_valid(out_valid),
        .out_stall(out_stall), .value(value)
    );

    mfek_flow_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .from_node(from_node),
        .to_node(to_node), .capacity(capacity), .out_valid(out_valid),
        .out_stall(out_stall), .value(value), .errors(errors), .pending(pending)
    );

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_gap_pct);

    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic send(cmd_t op, int src, int dst, int cap);
        while ($urandom_range(99) < send_gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cmd <= op;
        from_node <= 6'(src);
        to_node <= 6'(dst);
        capacity <= 16'(cap);
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic set_inner_nodes(int count);
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= 6'(count);
        @(posedge clk);
        cfg_we <= 1'b0;
        nodes = (count + 2 > MAX_NODES) ? MAX_NODES : count + 2;
    endtask

    function automatic int pick_capacity();
        int r;
        r = $urandom_range(99);
        if (r < 50)
            return $urandom_range(20, 1);
        if (r < 80)
            return $urandom_range(65535);
        if (r < 90)
            return 0;
        return 65535;
    endfunction

    task automatic random_item();
        int r;
        int run_pct;
        r = $urandom_range(999);
        run_pct = nodes > 16 ? 15 : 60;
        if (r < 450)
            send(CMD_WRITE, $urandom_range(nodes - 1), $urandom_range(nodes - 1), pick_capacity());
        else if (r < 520)
            send(CMD_WRITE, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
        else if (r < 520 + run_pct)
            send(CMD_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
        else if (r < 985)
            send(CMD_READ, $urandom_range(r < 900 ? nodes - 1 : 63),
                 $urandom_range(r < 900 ? nodes - 1 : 63), $urandom_range(65535));
        else
            send(CMD_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
    endtask

    int inner_setting [9] = '{2, 0, 62, 63, 5, 1, 8, 3, 12};

    initial
    begin
        nodes = 64;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        set_inner_nodes(inner_setting[0]);
        send(CMD_READ, 0, 1, 0);
        send(CMD_WRITE, 0, 1, 65535);
        send(CMD_WRITE, 1, 3, 65535);
        send(CMD_WRITE, 0, 2, 1);
        send(CMD_WRITE, 2, 3, 5);
        send(CMD_WRITE, 0, 3, 65535);
        send(CMD_WRITE, 3, 0, 7);
        send(CMD_RUN, 0, 0, 0);
        send(CMD_READ, 1, 0, 0);
        send(CMD_READ, 3, 2, 0);
        send(CMD_WRITE, 0, 3, 65535);
        send(CMD_RUN, 63, 63, 65535);
        send(CMD_WRITE, 0, 3, 65535);
        send(CMD_RUN, 0, 0, 0);
        send(CMD_READ, 3, 0, 0);
        send(CMD_WRITE, 63, 63, 65535);
        send(CMD_WRITE, 5, 9, 42);
        send(CMD_READ, 63, 63, 0);
        send(CMD_READ, 5, 9, 0);
        send(CMD_RUN, 0, 0, 0);
        send(CMD_CLEAR, 21, 42, 43690);
        send(CMD_READ, 63, 63, 21845);
        send(CMD_RUN, 0, 0, 0);

        for (int ph = 0; ph < 9; ph++)
        begin
            send_gap_pct = ph < 3 ? 7 : (ph < 6 ? 70 : 0);
            recv_gap_pct = ph < 3 ? 70 : (ph < 6 ? 7 : 0);
            set_inner_nodes(inner_setting[ph]);
            if (ph == 1)
            begin
                send(CMD_WRITE, 0, 1, 9);
                send(CMD_RUN, 0, 0, 0);
            end
            for (int i = 0; i < 200; i++)
                random_item();
            send(CMD_RUN, 0, 0, 0);
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
